>>> rtl/fp_pkg.sv
// Shared types and constants for the 48-bit Feistel permutation.
`timescale 1ns / 1ps
package fp_pkg;

	localparam int HALF_W     = 24;
	localparam int VALUE_W    = 2 * HALF_W;
	localparam int NUM_KEYS   = 4;
	localparam int KEY_SEL_W  = $clog2(NUM_KEYS);
	localparam int CFG_IDX_W  = 3;
	localparam int SHIFT_A    = 13;
	localparam int SHIFT_B    = 11;
	localparam int ROUNDS_DEF = 4;

	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	typedef logic [HALF_W-1:0] half_t;

	typedef struct packed {
		logic  valid;
		logic  op;
		half_t a;
		half_t b;
	} lane_t;

endpackage

>>> rtl/fp_cell.sv
// One Feistel round as a two-stage cell: b' = a ^ F(b), a' = b.
`timescale 1ns / 1ps
module fp_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  fp_pkg::lane_t lane_in,
	output logic          ready_up,
	input  fp_pkg::half_t key_fwd,
	input  fp_pkg::half_t key_inv,
	output fp_pkg::lane_t lane_out,
	input  logic          ready_down
);

	logic          v_s1, v_s2;
	logic          op_s1, op_s2;
	fp_pkg::half_t a_s1, b_s1, key_s1, p1_s1;
	fp_pkg::half_t a_s2, b_s2, p2_s2;
	fp_pkg::half_t key_sel, p1, m1, p2, f_out;
	logic          en_s1, en_s2;

	assign en_s2    = !v_s2 || ready_down;
	assign en_s1    = !v_s1 || en_s2;
	assign ready_up = en_s1;

	assign key_sel = (lane_in.op == fp_pkg::OP_INVERSE) ? key_inv : key_fwd;
	assign p1      = (lane_in.b ^ key_sel) * key_sel;
	assign m1      = p1_s1 ^ (p1_s1 >> fp_pkg::SHIFT_A);
	assign p2      = m1 * key_s1;
	assign f_out   = p2_s2 ^ (p2_s2 >> fp_pkg::SHIFT_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= lane_in.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && lane_in.valid) begin
			op_s1  <= lane_in.op;
			a_s1   <= lane_in.a;
			b_s1   <= lane_in.b;
			key_s1 <= key_sel;
			p1_s1  <= p1;
		end
		if (en_s2 && v_s1) begin
			op_s2 <= op_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			p2_s2 <= p2;
		end
	end

	assign lane_out.valid = v_s2;
	assign lane_out.op    = op_s2;
	assign lane_out.a     = b_s2;
	assign lane_out.b     = a_s2 ^ f_out;

`ifndef ASSERT_OFF
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		lane_in.valid && ready_up |=> v_s1)
		else $error("item taken by cell but first stage empty");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en_s2 |=> v_s2)
		else $error("first stage item lost on advance");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ready_down |=> v_s2 && $stable(p2_s2) && $stable(a_s2) && $stable(b_s2))
		else $error("stalled second stage changed");
`endif

endmodule

>>> rtl/feistel_permute_48.sv
// Top level of the keyed 48-bit Feistel permutation pipeline.
// Each item passes through ROUNDS round cells of two stages each and one output register;
// the first stage takes the item at its accepting edge, and each round multiplier is
// followed by its own register. A new item is taken every cycle while out_ready keeps
// results draining. Inverse items run the same cells with halves swapped at entry and
// exit and keys in reverse order. The round keys are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no item is in flight, which the block does
// not enforce. Indexes above three are ignored and only the low 24 bits are kept.
`timescale 1ns / 1ps
module feistel_permute_48 #(
	parameter int ROUNDS = fp_pkg::ROUNDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [fp_pkg::VALUE_W-1:0]   value_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fp_pkg::VALUE_W-1:0]   value_out,
	input  logic                         cfg_we,
	input  logic [fp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  fp_pkg::half_t                cfg_data
);

	localparam int HW = fp_pkg::HALF_W;

	fp_pkg::half_t keys_q [fp_pkg::NUM_KEYS];
	fp_pkg::lane_t lane [ROUNDS+1];
	logic          rdy  [ROUNDS+1];
	fp_pkg::half_t hi_in, lo_in;
	logic          out_valid_q;
	logic [fp_pkg::VALUE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fp_pkg::NUM_KEYS; i++) keys_q[i] <= '0;
		end else if (cfg_we && (cfg_index < fp_pkg::CFG_IDX_W'(fp_pkg::NUM_KEYS))) begin
			keys_q[cfg_index[fp_pkg::KEY_SEL_W-1:0]] <= cfg_data;
		end
	end

	assign hi_in = value_in[2*HW-1:HW];
	assign lo_in = value_in[HW-1:0];

	assign lane[0].valid = in_valid;
	assign lane[0].op    = operation;
	assign lane[0].a     = (operation == fp_pkg::OP_INVERSE) ? lo_in : hi_in;
	assign lane[0].b     = (operation == fp_pkg::OP_INVERSE) ? hi_in : lo_in;
	assign in_ready      = rdy[0];

	for (genvar j = 0; j < ROUNDS; j++) begin : g_round
		localparam int KF = j % fp_pkg::NUM_KEYS;
		localparam int KI = (ROUNDS - 1 - j) % fp_pkg::NUM_KEYS;
		fp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.lane_in   (lane[j]),
			.ready_up  (rdy[j]),
			.key_fwd   (keys_q[KF]),
			.key_inv   (keys_q[KI]),
			.lane_out  (lane[j+1]),
			.ready_down(rdy[j+1])
		);
	end

	assign rdy[ROUNDS] = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[ROUNDS]) begin
			out_valid_q <= lane[ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ROUNDS] && lane[ROUNDS].valid) begin
			value_q <= (lane[ROUNDS].op == fp_pkg::OP_INVERSE)
				? {lane[ROUNDS].b, lane[ROUNDS].a}
				: {lane[ROUNDS].a, lane[ROUNDS].b};
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_q;

`ifndef ASSERT_OFF
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with output register empty");
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		lane[ROUNDS].valid && rdy[ROUNDS] |=> out_valid_q)
		else $error("last cell item not captured in output register");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(value_q))
		else $error("stalled result changed");
`endif

endmodule

>>> tb/fp_permute_checker.sv
// Checker for the 48-bit Feistel permutation: tracks the round keys, predicts every result, compares.
`timescale 1ns / 1ps
module fp_permute_checker #(
	parameter int ROUNDS = fp_pkg::ROUNDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         operation,
	input  logic [fp_pkg::VALUE_W-1:0]   value_in,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [fp_pkg::VALUE_W-1:0]   value_out,
	input  logic                         cfg_we,
	input  logic [fp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  fp_pkg::half_t                cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           item_count,
	output int                           result_count
);

	localparam int SHOW_MAX = 10;

	fp_pkg::half_t              key_bank [fp_pkg::NUM_KEYS];
	logic [fp_pkg::VALUE_W-1:0] predicted_values [$];
	int                         mismatches;

	function automatic fp_pkg::half_t mix_half(input fp_pkg::half_t h, input fp_pkg::half_t k);
		fp_pkg::half_t r;
		r = h ^ k;
		r = r * k;
		r = r ^ (r >> fp_pkg::SHIFT_A);
		r = r * k;
		r = r ^ (r >> fp_pkg::SHIFT_B);
		return r;
	endfunction

	function automatic logic [fp_pkg::VALUE_W-1:0] permute48(input logic op,
			input logic [fp_pkg::VALUE_W-1:0] v);
		fp_pkg::half_t hi;
		fp_pkg::half_t lo;
		fp_pkg::half_t t;
		int            r;
		hi = v[fp_pkg::VALUE_W-1:fp_pkg::HALF_W];
		lo = v[fp_pkg::HALF_W-1:0];
		if (op == fp_pkg::OP_INVERSE) begin
			for (r = ROUNDS - 1; r >= 0; r--) begin
				t  = hi;
				hi = lo ^ mix_half(hi, key_bank[fp_pkg::KEY_SEL_W'(r)]);
				lo = t;
			end
		end else begin
			for (r = 0; r < ROUNDS; r++) begin
				t  = lo;
				lo = hi ^ mix_half(lo, key_bank[fp_pkg::KEY_SEL_W'(r)]);
				hi = t;
			end
		end
		return {hi, lo};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [fp_pkg::VALUE_W-1:0] want;
		if (!arst_n) begin
			foreach (key_bank[i])
				key_bank[i] = '0;
			predicted_values.delete();
			mismatches = 0;
			fail_count   <= 0;
			pending      <= 0;
			item_count   <= 0;
			result_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (predicted_values.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("[%0t] unexpected result: value_out=%h", $realtime, value_out);
				end else begin
					want = predicted_values.pop_front();
					if (value_out !== want) begin
						mismatches++;
						if (mismatches <= SHOW_MAX)
							$display("[%0t] value_out mismatch: expected %h, got %h",
								$realtime, want, value_out);
					end
				end
			end
			if (in_valid && in_ready) begin
				predicted_values.push_back(permute48(operation, value_in));
				item_count <= item_count + 1;
			end
			if (cfg_we && cfg_index < fp_pkg::NUM_KEYS)
				key_bank[cfg_index[fp_pkg::KEY_SEL_W-1:0]] = cfg_data;
			pending    <= predicted_values.size();
			fail_count <= mismatches;
		end
	end

endmodule

>>> tb/tb_top.sv
// Top-level testbench: clock, reset, key loading, item stimulus, output backpressure and verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int DRAIN_WAIT     = 2 * fp_pkg::ROUNDS_DEF + 3;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 100;
	localparam int NUM_CORNERS    = 10;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         operation = fp_pkg::OP_FORWARD;
	logic [fp_pkg::VALUE_W-1:0]   value_in = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [fp_pkg::VALUE_W-1:0]   value_out;
	logic                         cfg_we = 1'b0;
	logic [fp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	fp_pkg::half_t                cfg_data = '0;

	int fail_count;
	int pending;
	int item_count;
	int result_count;
	int cycles = 0;
	int key_settings = 0;

	bit gaps_on = 1'b1;
	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;

	fp_pkg::half_t key_plan [fp_pkg::NUM_KEYS];

	logic [fp_pkg::VALUE_W-1:0] corner_values [NUM_CORNERS] = '{
		48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FF00_0000, 48'h0000_00FF_FFFF,
		48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h8000_0000_0000, 48'h0000_0000_0001,
		48'h0000_0100_0000, 48'h0000_0080_0000
	};

	feistel_permute_48 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_out (value_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fp_permute_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.value_in     (value_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value_out    (value_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.item_count   (item_count),
		.result_count (result_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cycles, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic fp_pkg::half_t pick_key();
		unique case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return fp_pkg::half_t'(1);
			default: return fp_pkg::half_t'($urandom);
		endcase
	endfunction

	function automatic logic [fp_pkg::VALUE_W-1:0] pick_value();
		logic [63:0]                raw;
		logic [fp_pkg::VALUE_W-1:0] one_hot;
		raw = {$urandom, $urandom};
		one_hot = fp_pkg::VALUE_W'(1) << $urandom_range(0, fp_pkg::VALUE_W - 1);
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return {raw[fp_pkg::HALF_W-1:0], {fp_pkg::HALF_W{1'b0}}};
			4: return {{fp_pkg::HALF_W{1'b0}}, raw[fp_pkg::HALF_W-1:0]};
			default: return raw[fp_pkg::VALUE_W-1:0];
		endcase
	endfunction

	// Load key_plan into the key registers, plus one write to an unused index.
	task automatic write_keys();
		for (int i = 0; i < fp_pkg::NUM_KEYS; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= fp_pkg::CFG_IDX_W'(i);
			cfg_data  <= key_plan[i];
		end
		@(posedge clk);
		cfg_index <= fp_pkg::CFG_IDX_W'(fp_pkg::NUM_KEYS
			+ $urandom_range(0, 2 ** fp_pkg::CFG_IDX_W - fp_pkg::NUM_KEYS - 1));
		cfg_data  <= fp_pkg::half_t'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		key_settings++;
	endtask

	task automatic send_item(input logic op, input logic [fp_pkg::VALUE_W-1:0] v);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value_in  <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset keys: every round reduces to a half swap
		send_item(fp_pkg::OP_FORWARD, corner_values[0]);
		send_item(fp_pkg::OP_INVERSE, corner_values[1]);
		send_item(fp_pkg::OP_FORWARD, 48'h1234_5678_9ABC);
		send_item(fp_pkg::OP_INVERSE, 48'h1234_5678_9ABC);
		drain();

		foreach (key_plan[i])
			key_plan[i] = '1;
		write_keys();
		for (int c = 0; c < NUM_CORNERS; c++) begin
			send_item(fp_pkg::OP_FORWARD, corner_values[c]);
			send_item(fp_pkg::OP_INVERSE, corner_values[c]);
		end
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			foreach (key_plan[i]) begin
				unique case (p)
					0: key_plan[i] = '0;
					1: key_plan[i] = fp_pkg::half_t'(1);
					2: key_plan[i] = (i % 2 == 0) ? '0 : '1;
					default: key_plan[i] = pick_key();
				endcase
			end
			write_keys();
			gaps_on = (p < NUM_PHASES - 1);
			if (p == 3)
				squeeze_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item($urandom_range(0, 1) ? fp_pkg::OP_INVERSE : fp_pkg::OP_FORWARD,
					pick_value());
			drain();
		end

		$display("Checked %0d results from %0d items in both directions over %0d key settings,",
			result_count, item_count, key_settings);
		$display("with random idle bursts on both sides and a %0d-cycle output hold.",
			SQUEEZE_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/fp_pkg.sv
rtl/fp_cell.sv
rtl/feistel_permute_48.sv
tb/fp_permute_checker.sv
tb/tb_top.sv
